FILE: design/frac_n_pll_word_calc_top_assert.svh
// assertion macros shared by the lane and merge design files
`ifndef FRAC_N_PLL_WORD_CALC_TOP_ASSERT_SVH
`define FRAC_N_PLL_WORD_CALC_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PLLWC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pllwc assertion failed");
`define PLLWC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pllwc assertion failed");
`else
`define PLLWC_ASSERT(lbl, clk, rst_n, prop)
`define PLLWC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: design/pllwc_pkg.sv
`default_nettype none

package pllwc_pkg;

    localparam int FREQ_W = 33;
    localparam int REF_W  = 27;
    localparam int VCO_W  = 34;
    localparam int INT_W  = 11;
    localparam int FRAC_W = 23;
    localparam int CODE_W = 4;

    localparam logic [FRAC_W-1:0] FRAC_MODULUS = 23'h7FFFF1;
    localparam logic [7:0]        FRAC_SCALE   = 8'h80;

    localparam logic [REF_W-1:0] REF_FREQ_RST = 27'd40000000;
    localparam logic [VCO_W-1:0] VCO_MAX_RST  = 34'd12000000000;

    localparam logic CFG_REF_FREQ = 1'b0;
    localparam logic CFG_VCO_MAX  = 1'b1;

    typedef struct packed {
        logic              idle;
        logic              done;
        logic              err;
        logic [CODE_W-1:0] code;
        logic [INT_W-1:0]  int_word;
        logic [FRAC_W-1:0] frac_word;
    } t_lane_res;

endpackage

`default_nettype wire

FILE: design/pllwc_lane.sv
`default_nettype none

`include "frac_n_pll_word_calc_top_assert.svh"

module pllwc_lane
    import pllwc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [FREQ_W-1:0] i_freq,
    input  wire logic [REF_W-1:0]  i_ref,
    input  wire logic [VCO_W-1:0]  i_vco,
    input  wire logic              i_ack,
    output t_lane_res              o_res
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRCH = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_IDIV = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_FPRE = 4'd5;
    localparam logic [3:0] ST_FDIV = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam logic [4:0] MAX_SHIFT = 5'd16;

    logic [3:0]  r_state, n_state;
    logic [33:0] r_pll, n_pll;
    logic [4:0]  r_k, n_k;
    logic        r_err, n_err;
    logic [33:0] r_rem, n_rem;
    logic [36:0] r_div, n_div;
    logic [4:0]  r_cnt, n_cnt;
    logic [10:0] r_iq, n_iq;
    logic [49:0] r_num, n_num;
    logic [26:0] r_r, n_r;
    logic [29:0] r_sh, n_sh;
    logic [29:0] r_q, n_q;
    logic [22:0] r_frac, n_frac;

    logic [34:0] w_dbl;
    logic        w_dbl_ok;
    logic [37:0] w_lim;
    logic [36:0] w_remx, w_idiff;
    logic        w_ige;
    logic [49:0] w_prod;
    logic [27:0] w_t, w_refx, w_fdiff;
    logic        w_fge;
    logic [30:0] w_fsum;
    logic [4:0]  w_code;

    assign w_dbl    = {r_pll, 1'b0};
    assign w_dbl_ok = w_dbl <= {1'b0, i_vco};
    assign w_lim    = {i_ref, 11'b0};
    assign w_remx   = {3'b0, r_rem};
    assign w_idiff  = w_remx - r_div;
    assign w_ige    = w_remx >= r_div;
    assign w_prod   = {23'b0, r_rem[26:0]} * {27'b0, FRAC_MODULUS};
    assign w_t      = {r_r, r_sh[29]};
    assign w_refx   = {1'b0, i_ref};
    assign w_fdiff  = w_t - w_refx;
    assign w_fge    = w_t >= w_refx;
    assign w_fsum   = {1'b0, r_q} + 31'(FRAC_SCALE - 8'd1);
    assign w_code   = r_k - 5'd1;

    always_comb begin
        n_state = r_state;
        n_pll   = r_pll;
        n_k     = r_k;
        n_err   = r_err;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_iq    = r_iq;
        n_num   = r_num;
        n_r     = r_r;
        n_sh    = r_sh;
        n_q     = r_q;
        n_frac  = r_frac;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_pll = {1'b0, i_freq};
                    n_k   = '0;
                    n_err = (i_freq == '0);
                    n_state = (i_freq == '0) ? ST_DONE : ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (w_dbl_ok) begin
                    if (r_k == MAX_SHIFT) begin
                        n_err   = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_pll = w_dbl[33:0];
                        n_k   = r_k + 5'd1;
                    end
                end else if (r_k == '0) begin
                    n_err   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                // integer word must fit in 11 bits, also catches a zero reference
                if ({4'b0, r_pll} >= w_lim) begin
                    n_err   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_rem   = r_pll;
                    n_div   = {i_ref, 10'b0};
                    n_cnt   = 5'd10;
                    n_iq    = '0;
                    n_state = ST_IDIV;
                end
            end
            ST_IDIV: begin
                if (w_ige) begin
                    n_rem = w_idiff[33:0];
                end
                n_iq  = {r_iq[9:0], w_ige};
                n_div = {1'b0, r_div[36:1]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_num   = w_prod;
                n_state = ST_FPRE;
            end
            ST_FPRE: begin
                n_r     = r_num[49:23];
                n_sh    = {r_num[22:0], 7'b0};
                n_q     = '0;
                n_cnt   = 5'd29;
                n_state = ST_FDIV;
            end
            ST_FDIV: begin
                n_r   = w_fge ? w_fdiff[26:0] : w_t[26:0];
                n_sh  = {r_sh[28:0], 1'b0};
                n_q   = {r_q[28:0], w_fge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // round up to the 23-bit fraction
                n_frac  = w_fsum[29:7];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pll  <= n_pll;
        r_k    <= n_k;
        r_err  <= n_err;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_cnt  <= n_cnt;
        r_iq   <= n_iq;
        r_num  <= n_num;
        r_r    <= n_r;
        r_sh   <= n_sh;
        r_q    <= n_q;
        r_frac <= n_frac;
    end

    always_comb begin
        o_res.idle      = (r_state == ST_IDLE);
        o_res.done      = (r_state == ST_DONE);
        o_res.err       = r_err;
        o_res.code      = w_code[3:0];
        o_res.int_word  = r_iq;
        o_res.frac_word = r_frac;
    end

    `PLLWC_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> (r_state == ST_IDLE))
    `PLLWC_ASSERT(a_shift_bound, i_clk, i_rst_n, (r_state == ST_SRCH) |-> (r_k <= MAX_SHIFT))
    `PLLWC_ASSERT(a_done_hold, i_clk, i_rst_n,
        (r_state == ST_DONE && !i_ack) |=> (r_state == ST_DONE))

endmodule

`default_nettype wire

FILE: design/pllwc_merge.sv
`default_nettype none

`include "frac_n_pll_word_calc_top_assert.svh"

module pllwc_merge
    import pllwc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_lane_res  i_rx,
    input  wire t_lane_res  i_tx,
    input  wire logic       i_tready,
    output logic            o_ack,
    output logic            o_tvalid,
    output logic [79:0]     o_tdata,
    output logic            o_tuser
);

    logic        r_valid;
    logic [79:0] r_data;
    logic        r_user;
    logic        w_err;

    assign w_err = i_rx.err | i_tx.err;
    assign o_ack = i_rx.done & i_tx.done & (!r_valid | i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ack) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
        if (o_ack) begin
            r_user <= w_err;
            if (w_err) begin
                r_data <= '0;
            end else begin
                r_data <= {4'b0, i_tx.frac_word, i_tx.int_word,
                           i_rx.frac_word, i_rx.int_word, i_tx.code, i_rx.code};
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;

    `PLLWC_ASSERT(a_ack_loads, i_clk, i_rst_n, o_ack |=> r_valid)
    `PLLWC_ASSERT(a_err_zero, i_clk, i_rst_n, (r_valid && r_user) |-> (r_data == '0))
    `PLLWC_ASSERT_ALWAYS(a_pad_zero, i_clk, r_valid |-> (r_data[79:76] == 4'b0))

endmodule

`default_nettype wire

FILE: design/frac_n_pll_word_calc_top.sv
// fractional-n pll word calculator
// s_axis carries one request: rx and tx lo frequencies in hz. each request gives one
// result on m_axis: divider code byte, rx and tx integer and fractional words, and
// range_error in tuser (all words zero when it is set).
// the cfg write channel sets ref_freq (index 0) and vco_max_freq (index 1); it is
// always ready and should only be written while no request is in flight.
// rx and tx run in two lanes side by side, each with a shift search for the vco
// divider, an 11-step integer divider, one multiply and a 30-step
// fractional divider; a merge stage packs both into the output register.
// a new request is taken only after both lanes have handed their results to the
// merge stage and returned to idle.
// s_axis_tready is high while both lanes are free; a finished result waiting in the
// output register does not block the next request, but lanes hold their result
// when the receiver stalls with the output register still full.
// reset (synchronous, active low) empties the lanes and output register and loads
// ref_freq = 40 mhz and vco_max_freq = 12 ghz.
`default_nettype none

module frac_n_pll_word_calc_top
    import pllwc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // rx_freq[32:0], tx_freq[65:33], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // divider_code[7:0], rx_int_word[18:8],
                                             // rx_frac_word[41:19], tx_int_word[52:42],
                                             // tx_frac_word[75:53], zero pad
    output logic             m_axis_tuser,   // range_error
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [33:0] i_cfg_data
);

    logic [REF_W-1:0] r_ref_freq;
    logic [VCO_W-1:0] r_vco_max;
    logic             w_start;
    t_lane_res        w_rx_res;
    t_lane_res        w_tx_res;
    logic             w_ack;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq <= REF_FREQ_RST;
            r_vco_max  <= VCO_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REF_FREQ: r_ref_freq <= i_cfg_data[26:0];
                CFG_VCO_MAX:  r_vco_max  <= i_cfg_data;
                default:      r_vco_max  <= r_vco_max;
            endcase
        end
    end

    assign s_axis_tready = w_rx_res.idle & w_tx_res.idle;
    assign w_start       = s_axis_tvalid & s_axis_tready;

    pllwc_lane u_rx_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_freq  (s_axis_tdata[32:0]),
        .i_ref   (r_ref_freq),
        .i_vco   (r_vco_max),
        .i_ack   (w_ack),
        .o_res   (w_rx_res)
    );

    pllwc_lane u_tx_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_freq  (s_axis_tdata[65:33]),
        .i_ref   (r_ref_freq),
        .i_vco   (r_vco_max),
        .i_ack   (w_ack),
        .o_res   (w_tx_res)
    );

    pllwc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (w_rx_res),
        .i_tx     (w_tx_res),
        .i_tready (m_axis_tready),
        .o_ack    (w_ack),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/pll_word_checker.sv
module pll_word_checker
    import pllwc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [71:0] i_req_data,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [79:0] i_res_data,
    input  wire logic        i_res_user,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [33:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam longint unsigned FRAC_MOD   = 64'd8388593;
    localparam longint unsigned FRAC_STEPS = 64'd128;
    localparam longint unsigned INT_MAX    = 64'd2047;
    localparam int              CODE_MAX   = 15;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
        logic [INT_W-1:0]  int_word;
        logic [FRAC_W-1:0] frac_word;
    } lane_words_t;

    typedef struct packed {
        logic [7:0]        divider_code;
        logic [INT_W-1:0]  rx_int;
        logic [FRAC_W-1:0] rx_frac;
        logic [INT_W-1:0]  tx_int;
        logic [FRAC_W-1:0] tx_frac;
        logic              range_error;
    } tune_words_t;

    longint unsigned ref_hz     = 64'd40000000;
    longint unsigned vco_top_hz = 64'd12000000000;
    tune_words_t     expected_words[$];
    int              mismatches = 0;

    assign o_fail_count = mismatches;

    // one lo path: power-of-two vco divider, integer and fractional words
    function automatic lane_words_t lane_words(longint unsigned lo_hz);
        lane_words_t     lane;
        longint unsigned ratio;
        longint unsigned pll_hz;
        longint unsigned int_word;
        longint unsigned rem;
        longint unsigned scaled;
        int              shift;
        lane = '0;
        if (lo_hz == 0 || ref_hz == 0) return lane;
        ratio = vco_top_hz / lo_hz;
        if (ratio < 2) return lane;
        shift = 0;
        while ((ratio >> (shift + 1)) != 0) shift++;
        if (shift - 1 > CODE_MAX) return lane;
        pll_hz = lo_hz << shift;
        int_word = pll_hz / ref_hz;
        if (int_word > INT_MAX) return lane;
        rem = pll_hz - int_word * ref_hz;
        scaled = rem * FRAC_MOD * FRAC_STEPS / ref_hz;
        lane.ok = 1'b1;
        lane.code = CODE_W'(shift - 1);
        lane.int_word = INT_W'(int_word);
        // rounding up may land exactly on the modulus, kept as is
        lane.frac_word = FRAC_W'((scaled + FRAC_STEPS - 1) / FRAC_STEPS);
        return lane;
    endfunction

    function automatic tune_words_t tune_words(logic [71:0] req);
        lane_words_t rx;
        lane_words_t tx;
        tune_words_t res;
        rx = lane_words(req[32:0]);
        tx = lane_words(req[65:33]);
        res = '0;
        if (rx.ok && tx.ok) begin
            res.divider_code = {tx.code, rx.code};
            res.rx_int = rx.int_word;
            res.rx_frac = rx.frac_word;
            res.tx_int = tx.int_word;
            res.tx_frac = tx.frac_word;
        end else begin
            res.range_error = 1'b1;
        end
        return res;
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        tune_words_t want;
        tune_words_t got;
        if (!i_rst_n) begin
            ref_hz = 64'd40000000;
            vco_top_hz = 64'd12000000000;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_REF_FREQ)
                    ref_hz = i_cfg_data[REF_W-1:0];
                else
                    vco_top_hz = i_cfg_data;
            end
            if (i_req_valid && i_req_ready)
                expected_words.push_back(tune_words(i_req_data));
            if (i_res_valid && i_res_ready) begin
                got.divider_code = i_res_data[7:0];
                got.rx_int = i_res_data[18:8];
                got.rx_frac = i_res_data[41:19];
                got.tx_int = i_res_data[52:42];
                got.tx_frac = i_res_data[75:53];
                got.range_error = i_res_user;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none, got code %0h range_error %0b",
                             $time, got.divider_code, got.range_error);
                end else begin
                    want = expected_words.pop_front();
                    check_field("divider_code", want.divider_code, got.divider_code);
                    check_field("rx_int_word", want.rx_int, got.rx_int);
                    check_field("rx_frac_word", want.rx_frac, got.rx_frac);
                    check_field("tx_int_word", want.tx_int, got.tx_int);
                    check_field("tx_frac_word", want.tx_frac, got.tx_frac);
                    check_field("range_error", want.range_error, got.range_error);
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

FILE: tb/frac_n_pll_word_calc_top_test.sv
module frac_n_pll_word_calc_top_test;
    import pllwc_pkg::*;

    localparam int              CYCLE_LIMIT   = 1000000;
    localparam int              SETTLE_CYCLES = 80;
    localparam int              LONG_HOLD     = 500;
    localparam longint unsigned FREQ_TOP      = 64'h1_FFFF_FFFF;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = 1'b0;
    logic [33:0] i_cfg_data    = '0;

    int              fail_count;
    int              pending;
    int              cycle_count   = 0;
    int              hold_requests = 0;
    bit              sender_idles  = 1'b1;
    longint unsigned vco_now       = 64'd12000000000;

    frac_n_pll_word_calc_top u_dut (
        .i_clk,
        .i_rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_index,
        .i_cfg_data
    );

    pll_word_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned pick_between(longint unsigned lo, longint unsigned hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return lo + r % (hi - lo + 1);
    endfunction

    // mostly in-range lo frequencies spread over all divider codes, plus edges and noise
    function automatic longint unsigned pick_lo_freq();
        int sel;
        int k;
        sel = $urandom_range(0, 19);
        k = $urandom_range(1, 16);
        if (sel < 14)
            return pick_between((vco_now >> (k + 1)) + 1, vco_now >> k) & FREQ_TOP;
        else if (sel == 14)
            return pick_between(0, FREQ_TOP);
        else if (sel == 15)
            return pick_between(1, 200000);
        else if (sel <= 17)
            return ((vco_now >> $urandom_range(0, 18)) + $urandom_range(0, 4) - 2) & FREQ_TOP;
        else if (sel == 18)
            return pick_between(vco_now >> 1, FREQ_TOP);
        else if ($urandom_range(0, 1) != 0)
            return FREQ_TOP;
        else
            return $urandom_range(0, 2);
    endfunction

    task automatic write_reg(logic idx, longint unsigned value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[33:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_request(longint unsigned rx_hz, longint unsigned tx_hz);
        int gap;
        gap = 0;
        if (sender_idles) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = $urandom_range(1, 3);
                3: gap = $urandom_range(15, 60);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, tx_hz[32:0], rx_hz[32:0]};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic stop_and_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(longint unsigned ref_hz, longint unsigned vco_hz, int count);
        write_reg(CFG_REF_FREQ, ref_hz);
        write_reg(CFG_VCO_MAX, vco_hz);
        vco_now = vco_hz;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0)
                sender_idles = $urandom_range(0, 3) != 0;
            send_request(pick_lo_freq(), pick_lo_freq());
        end
        stop_and_drain();
    endtask

    initial begin : receiver
        int stall_left;
        int stretch_left;
        int holds_seen;
        bit stalls_on;
        stall_left = 0;
        stretch_left = 0;
        holds_seen = 0;
        stalls_on = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(100, 400);
                stalls_on = $urandom_range(0, 3) != 0;
            end
            stretch_left--;
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (stalls_on && i_rst_n) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: stall_left = $urandom_range(1, 4);
                        3: stall_left = $urandom_range(20, 60);
                        default: stall_left = 0;
                    endcase
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: 40 mhz reference, 12 ghz vco top
        send_request(64'd6000000000, 64'd6000000000);
        send_request(1, 1);
        send_request(0, 64'd40000000);
        send_request(64'd40000000, 0);
        send_request(FREQ_TOP, 64'd100000000);
        send_request(64'd1, FREQ_TOP);
        send_request(64'd6000000001, 64'd2400000000);
        send_request(64'd5999999999, 64'd5999999999);
        send_request(64'd2400000000, 64'd2400000000);
        send_request(64'd91553, 64'd91553);
        send_request(64'd91552, 64'd1000000000);
        send_request(64'd46875000, 64'd46875001);
        send_request(64'd70000000, 64'd3000000000);
        send_request(64'd3000000001, 64'd1000000000);
        send_request(64'h1_5555_5555, 64'h0_AAAA_AAAA);
        send_request(64'h0_AAAA_AAAA, 64'h1_5555_5555);
        send_request(64'd12000000000 & FREQ_TOP, 64'd100000);
        stop_and_drain();

        run_phase(64'd35000000, 64'd6000000000, 250);
        hold_requests++;
        run_phase(64'd80000000, 64'd12000000000, 250);
        run_phase(64'd80000000, 64'd6000000000, 220);
        run_phase(pick_between(35000000, 80000000),
                  pick_between(64'd6000000000, 64'd12000000000), 250);
        run_phase(0, 64'd12000000000, 40);
        run_phase(64'd3000000, 64'd12000000000, 80);
        run_phase(64'h7FF_FFFF, 64'h3_FFFF_FFFF, 220);
        run_phase(pick_between(35000000, 80000000),
                  pick_between(64'd6000000000, 64'd12000000000), 250);
        run_phase(64'd40000000, 64'd12000000000, 300);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
